// File: sv/dht_pkg.sv
`default_nettype none

package dht_pkg;

   // Marker bytes of a DHT segment
   localparam logic [7:0] MARKER_FF  = 8'hFF;
   localparam logic [7:0] MARKER_DHT = 8'hC4;

   // Number of code-length counts per table, longest code allowed
   localparam int NUM_LEVELS      = 16;
   localparam int MAX_CODE_LENGTH = 16;

   // Result status codes
   localparam logic [2:0] ST_ENTRY      = 3'd0;
   localparam logic [2:0] ST_EMPTY      = 3'd1;
   localparam logic [2:0] ST_BAD_MARKER = 3'd2;
   localparam logic [2:0] ST_OVERSUB    = 3'd3;
   localparam logic [2:0] ST_OVERRUN    = 3'd4;

   // Parser phases; PH_SKIP walks past empty code lengths
   typedef enum logic [3:0] {
      PH_MARK_FF,
      PH_MARK_C4,
      PH_LEN_HI,
      PH_LEN_LO,
      PH_INFO,
      PH_COUNTS,
      PH_SYMS,
      PH_SKIP,
      PH_IDLE
   } phase_type;

   // Controller to datapath
   typedef struct packed {
      logic       clear_marker;
      logic       load_len_hi;
      logic       load_len_lo;
      logic       count_byte;
      logic       load_info;
      logic       write_count;
      logic       start_codes;
      logic       emit_sym;
      logic       skip_step;
      logic       skip_done;
      logic       push;
      logic       res_entry;
      logic       res_lt;
      logic       res_ls;
      logic [2:0] res_status;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic byte_ff;
      logic byte_dht;
      logic len_short;
      logic len_two;
      logic at_end;
      logic last_count;
      logic oversub;
      logic total_zero;
      logic sym_last;
      logic level_advance;
      logic skip_more;
   } sts_type;

   // One result beat
   typedef struct packed {
      logic [3:0]  table_class;
      logic [3:0]  table_id;
      logic [7:0]  symbol_value;
      logic [15:0] code_bits;
      logic [4:0]  code_length;
      logic        last_of_table;
      logic        last_of_segment;
      logic [2:0]  status;
   } rsp_type;

endpackage

`default_nettype wire

// File: sv/dht_req_if.sv
`default_nettype none

interface dht_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       first_byte;

   modport source (output valid, output data_byte, output first_byte, input ready);
   modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

`default_nettype wire

// File: sv/dht_rsp_if.sv
`default_nettype none

interface dht_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  table_class;
   logic [3:0]  table_id;
   logic [7:0]  symbol_value;
   logic [15:0] code_bits;
   logic [4:0]  code_length;
   logic        last_of_table;
   logic        last_of_segment;
   logic [2:0]  status;

   modport source (
      output valid, output table_class, output table_id, output symbol_value,
      output code_bits, output code_length, output last_of_table,
      output last_of_segment, output status, input ready
   );
   modport sink (
      input valid, input table_class, input table_id, input symbol_value,
      input code_bits, input code_length, input last_of_table,
      input last_of_segment, input status, output ready
   );
endinterface

`default_nettype wire

// File: sv/dht_segment_huffman_code_builder_core.sv
// DHT segment canonical Huffman code builder.
// req_if carries one segment byte per beat (data_byte, first_byte); a beat
// with first_byte set restarts parsing at the FF C4 marker. rsp_if carries
// one code entry per symbol byte, plus notice beats (empty table) and error
// beats (bad marker, over-subscribed counts, segment overrun) which also end
// the segment.
// Marker, length, class/id and count bytes are accepted whenever the result
// queue has space. A symbol byte that finishes a code length is followed by
// a scan of the count table, one length per cycle, stepping past empty
// lengths. The sixteenth count starts the same scan from length 1.
// A result beat is pushed into the result queue when its byte is accepted.
// Results go through a two-beat queue; the byte side keeps running while a
// beat waits, and req_if.ready drops only when the queue is full or during
// the length scan.
// Reset: queue emptied, parser waits for the first marker byte (the first
// byte after reset is taken as a marker byte even without first_byte).
`default_nettype none

module dht_segment_huffman_code_builder_core import dht_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   dht_req_if.sink    req_if,
   dht_rsp_if.source  rsp_if
);

   cmd_type cmd;
   sts_type sts;
   rsp_type rsp_new;
   rsp_type rsp_out;
   logic    space;

   // Parser state machine
   dht_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_if.valid),
      .first_byte (req_if.first_byte),
      .space      (space),
      .sts        (sts),
      .req_ready  (req_if.ready),
      .cmd        (cmd)
   );

   // Counters, count table and code generator
   dht_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .data_byte (req_if.data_byte),
      .sts       (sts),
      .rsp       (rsp_new)
   );

   // Result queue
   dht_obuf u_obuf (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd.push),
      .push_data (rsp_new),
      .space     (space),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .out_data  (rsp_out)
   );

   assign rsp_if.table_class     = rsp_out.table_class;
   assign rsp_if.table_id        = rsp_out.table_id;
   assign rsp_if.symbol_value    = rsp_out.symbol_value;
   assign rsp_if.code_bits       = rsp_out.code_bits;
   assign rsp_if.code_length     = rsp_out.code_length;
   assign rsp_if.last_of_table   = rsp_out.last_of_table;
   assign rsp_if.last_of_segment = rsp_out.last_of_segment;
   assign rsp_if.status          = rsp_out.status;

endmodule

`default_nettype wire

// File: sv/dht_dp.sv
`default_nettype none

module dht_dp import dht_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cmd_type    cmd,
   input  wire logic [7:0] data_byte,
   output sts_type         sts,
   output rsp_type         rsp
);

   logic [15:0] seg_len_ff,   seg_len_in;
   logic [15:0] consumed_ff,  consumed_in;
   logic [3:0]  class_ff,     class_in;
   logic [3:0]  id_ff,        id_in;
   logic [3:0]  count_idx_ff, count_idx_in;
   logic [16:0] avail_ff,     avail_in;
   logic        over_ff,      over_in;
   logic [11:0] total_ff,     total_in;
   logic [4:0]  level_ff,     level_in;
   logic [16:0] code_ff,      code_in;
   logic [7:0]  left_ff,      left_in;
   logic [11:0] syms_left_ff, syms_left_in;
   logic [7:0]  counts_ff [NUM_LEVELS];

   logic [15:0] consumed_inc;
   logic [15:0] seg_full;
   logic [16:0] avail_dbl;
   logic [4:0]  count_lvl;
   logic        over_now;
   logic [11:0] total_now;
   logic [3:0]  lvl_idx;
   logic [7:0]  lvl_count;
   logic [16:0] code_inc;
   logic [7:0]  left_dec;

   // Shared arithmetic
   always_comb begin
      consumed_inc = consumed_ff + 16'd1;
      seg_full     = {seg_len_ff[15:8], data_byte};
      avail_dbl    = {avail_ff[15:0], 1'b0};
      count_lvl    = {1'b0, count_idx_ff} + 5'd1;
      // running Kraft check: this length's count against free codes
      over_now     = over_ff
                   | ({9'd0, data_byte} > avail_dbl)
                   | ((count_lvl > 5'(MAX_CODE_LENGTH)) && (data_byte != 8'd0));
      total_now    = total_ff + {4'd0, data_byte};
      lvl_idx      = 4'(level_ff - 5'd1);
      lvl_count    = counts_ff[lvl_idx];
      code_inc     = code_ff + 17'd1;
      left_dec     = left_ff - 8'd1;
   end

   // Status to controller
   always_comb begin
      sts.byte_ff       = (data_byte == MARKER_FF);
      sts.byte_dht      = (data_byte == MARKER_DHT);
      sts.len_short     = (seg_full < 16'd2);
      sts.len_two       = (seg_full == 16'd2);
      sts.at_end        = (consumed_inc == seg_len_ff);
      sts.last_count    = (count_idx_ff == 4'(NUM_LEVELS - 1));
      sts.oversub       = over_now;
      sts.total_zero    = (total_now == 12'd0);
      sts.sym_last      = (syms_left_ff <= 12'd1);
      sts.level_advance = (left_dec == 8'd0) && (level_ff < 5'(NUM_LEVELS));
      sts.skip_more     = (level_ff < 5'(NUM_LEVELS)) && (lvl_count == 8'd0);
   end

   // Next-state of the datapath registers
   always_comb begin
      seg_len_in   = seg_len_ff;
      consumed_in  = consumed_ff;
      class_in     = class_ff;
      id_in        = id_ff;
      count_idx_in = count_idx_ff;
      avail_in     = avail_ff;
      over_in      = over_ff;
      total_in     = total_ff;
      level_in     = level_ff;
      code_in      = code_ff;
      left_in      = left_ff;
      syms_left_in = syms_left_ff;

      if (cmd.clear_marker) begin
         class_in = 4'd0;
         id_in    = 4'd0;
      end
      if (cmd.load_len_hi) begin
         seg_len_in  = {data_byte, 8'd0};
         consumed_in = 16'd1;
      end
      if (cmd.load_len_lo) begin
         seg_len_in  = seg_full;
         consumed_in = 16'd2;
      end
      if (cmd.count_byte) begin
         consumed_in = consumed_inc;
      end
      if (cmd.load_info) begin
         class_in     = data_byte[7:4];
         id_in        = data_byte[3:0];
         count_idx_in = 4'd0;
         avail_in     = 17'd1;
         over_in      = 1'b0;
         total_in     = 12'd0;
      end
      if (cmd.write_count) begin
         count_idx_in = count_idx_ff + 4'd1;
         avail_in     = avail_dbl - {9'd0, data_byte};
         over_in      = over_now;
         total_in     = total_now;
      end
      if (cmd.start_codes) begin
         level_in     = 5'd1;
         code_in      = 17'd0;
         syms_left_in = total_now;
      end
      if (cmd.emit_sym) begin
         code_in      = code_inc;
         left_in      = left_dec;
         syms_left_in = sts.sym_last ? 12'd0 : syms_left_ff - 12'd1;
         // length finished: shift code and move to the next length
         if (!sts.sym_last && sts.level_advance) begin
            code_in  = {code_inc[15:0], 1'b0};
            level_in = level_ff + 5'd1;
         end
      end
      if (cmd.skip_step) begin
         code_in  = {code_ff[15:0], 1'b0};
         level_in = level_ff + 5'd1;
      end
      if (cmd.skip_done) begin
         left_in = lvl_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_len_ff   <= '0;
         consumed_ff  <= '0;
         class_ff     <= '0;
         id_ff        <= '0;
         count_idx_ff <= '0;
         avail_ff     <= 17'd1;
         over_ff      <= 1'b0;
         total_ff     <= '0;
         level_ff     <= 5'd1;
         code_ff      <= '0;
         left_ff      <= '0;
         syms_left_ff <= '0;
      end else begin
         seg_len_ff   <= seg_len_in;
         consumed_ff  <= consumed_in;
         class_ff     <= class_in;
         id_ff        <= id_in;
         count_idx_ff <= count_idx_in;
         avail_ff     <= avail_in;
         over_ff      <= over_in;
         total_ff     <= total_in;
         level_ff     <= level_in;
         code_ff      <= code_in;
         left_ff      <= left_in;
         syms_left_ff <= syms_left_in;
      end
   end

   // Code-length counts of the current table
   always_ff @(posedge clock) begin
      if (cmd.write_count) begin
         counts_ff[count_idx_ff] <= data_byte;
      end
   end

   // Result beat for this byte
   always_comb begin
      if (cmd.load_info) begin
         rsp.table_class = data_byte[7:4];
         rsp.table_id    = data_byte[3:0];
      end else if (cmd.clear_marker) begin
         rsp.table_class = 4'd0;
         rsp.table_id    = 4'd0;
      end else begin
         rsp.table_class = class_ff;
         rsp.table_id    = id_ff;
      end
      rsp.symbol_value    = cmd.res_entry ? data_byte     : 8'd0;
      rsp.code_bits       = cmd.res_entry ? code_ff[15:0] : 16'd0;
      rsp.code_length     = cmd.res_entry ? level_ff      : 5'd0;
      rsp.last_of_table   = cmd.res_lt;
      rsp.last_of_segment = cmd.res_ls;
      rsp.status          = cmd.res_status;
   end

endmodule

`default_nettype wire

// File: sv/dht_ctrl.sv
`default_nettype none

module dht_ctrl import dht_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic    first_byte,
   input  wire logic    space,
   input  wire sts_type sts,
   output logic         req_ready,
   output cmd_type      cmd
);

   phase_type phase_ff, phase_in;
   phase_type eff_phase;
   logic      accept;

   // first_byte resyncs to the marker from any phase but PH_SKIP
   always_comb begin
      req_ready = (phase_ff != PH_SKIP) && space;
      accept    = req_valid && req_ready;
      eff_phase = (first_byte && (phase_ff != PH_SKIP)) ? PH_MARK_FF : phase_ff;
   end

   // Next state
   always_comb begin
      phase_in = phase_ff;
      case (eff_phase)
         PH_MARK_FF: begin
            if (accept) phase_in = sts.byte_ff ? PH_MARK_C4 : PH_IDLE;
         end
         PH_MARK_C4: begin
            if (accept) phase_in = sts.byte_dht ? PH_LEN_HI : PH_IDLE;
         end
         PH_LEN_HI: begin
            if (accept) phase_in = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            if (accept) phase_in = (sts.len_short || sts.len_two) ? PH_IDLE : PH_INFO;
         end
         PH_INFO: begin
            if (accept) phase_in = sts.at_end ? PH_IDLE : PH_COUNTS;
         end
         PH_COUNTS: begin
            if (accept) begin
               if (!sts.last_count) begin
                  phase_in = sts.at_end ? PH_IDLE : PH_COUNTS;
               end else if (sts.oversub) begin
                  phase_in = PH_IDLE;
               end else if (sts.total_zero) begin
                  phase_in = sts.at_end ? PH_IDLE : PH_INFO;
               end else begin
                  phase_in = sts.at_end ? PH_IDLE : PH_SKIP;
               end
            end
         end
         PH_SYMS: begin
            if (accept) begin
               if (sts.at_end && !sts.sym_last) begin
                  phase_in = PH_IDLE;
               end else if (sts.sym_last) begin
                  phase_in = sts.at_end ? PH_IDLE : PH_INFO;
               end else if (sts.level_advance) begin
                  phase_in = PH_SKIP;
               end else begin
                  phase_in = PH_SYMS;
               end
            end
         end
         PH_SKIP: begin
            if (!sts.skip_more) phase_in = PH_SYMS;
         end
         PH_IDLE: begin
            phase_in = PH_IDLE;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   // Commands
   always_comb begin
      cmd = '0;
      case (eff_phase)
         PH_MARK_FF: begin
            if (accept) begin
               cmd.clear_marker = 1'b1;
               if (!sts.byte_ff) begin
                  cmd.push       = 1'b1;
                  cmd.res_ls     = 1'b1;
                  cmd.res_status = ST_BAD_MARKER;
               end
            end
         end
         PH_MARK_C4: begin
            if (accept && !sts.byte_dht) begin
               cmd.push       = 1'b1;
               cmd.res_ls     = 1'b1;
               cmd.res_status = ST_BAD_MARKER;
            end
         end
         PH_LEN_HI: begin
            cmd.load_len_hi = accept;
         end
         PH_LEN_LO: begin
            if (accept) begin
               cmd.load_len_lo = 1'b1;
               if (sts.len_short) begin
                  cmd.push       = 1'b1;
                  cmd.res_ls     = 1'b1;
                  cmd.res_status = ST_OVERRUN;
               end
            end
         end
         PH_INFO: begin
            if (accept) begin
               cmd.count_byte = 1'b1;
               cmd.load_info  = 1'b1;
               if (sts.at_end) begin
                  cmd.push       = 1'b1;
                  cmd.res_ls     = 1'b1;
                  cmd.res_status = ST_OVERRUN;
               end
            end
         end
         PH_COUNTS: begin
            if (accept) begin
               cmd.count_byte  = 1'b1;
               cmd.write_count = 1'b1;
               if (!sts.last_count) begin
                  if (sts.at_end) begin
                     cmd.push       = 1'b1;
                     cmd.res_ls     = 1'b1;
                     cmd.res_status = ST_OVERRUN;
                  end
               end else if (sts.oversub) begin
                  cmd.push       = 1'b1;
                  cmd.res_ls     = 1'b1;
                  cmd.res_status = ST_OVERSUB;
               end else if (sts.total_zero) begin
                  cmd.push       = 1'b1;
                  cmd.res_lt     = 1'b1;
                  cmd.res_ls     = sts.at_end;
                  cmd.res_status = ST_EMPTY;
               end else if (sts.at_end) begin
                  cmd.push       = 1'b1;
                  cmd.res_ls     = 1'b1;
                  cmd.res_status = ST_OVERRUN;
               end else begin
                  cmd.start_codes = 1'b1;
               end
            end
         end
         PH_SYMS: begin
            if (accept) begin
               cmd.count_byte = 1'b1;
               cmd.push       = 1'b1;
               if (sts.at_end && !sts.sym_last) begin
                  cmd.res_ls     = 1'b1;
                  cmd.res_status = ST_OVERRUN;
               end else begin
                  cmd.emit_sym   = 1'b1;
                  cmd.res_entry  = 1'b1;
                  cmd.res_lt     = sts.sym_last;
                  cmd.res_ls     = sts.sym_last && sts.at_end;
                  cmd.res_status = ST_ENTRY;
               end
            end
         end
         PH_SKIP: begin
            cmd.skip_step = sts.skip_more;
            cmd.skip_done = !sts.skip_more;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_MARK_FF;
      end else begin
         phase_ff <= phase_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/dht_obuf.sv
`default_nettype none

module dht_obuf import dht_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire rsp_type push_data,
   output logic         space,
   output logic         out_valid,
   input  wire logic    out_ready,
   output rsp_type      out_data
);

   rsp_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff,    cnt_in;
   logic       pop;

   // Two-beat result queue
   always_comb begin
      out_valid = (cnt_ff != 2'd0);
      space     = (cnt_ff != 2'd2);
      out_data  = entry_ff[rd_ptr_ff];
      pop       = out_valid && out_ready;
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// File: test/dht_segment_huffman_code_builder_core_tb.sv
`timescale 1ns / 1ps

module dht_segment_huffman_code_builder_core_tb import dht_pkg::*; ();

   localparam int RANDOM_BYTES = 450;
   localparam int TAIL_CYCLES  = 40;

   logic clock;
   logic reset;

   dht_req_if req_if ();
   dht_rsp_if rsp_if ();

   dht_segment_huffman_code_builder_core u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // Code entries, notices and error beats still owed by the block, oldest first
   rsp_type pending_codes[$];
   int      mismatch_count = 0;

   // Idle/stall controls
   bit          gaps_on    = 1'b0;
   bit          stall_on   = 1'b0;
   int          burst_left = 0;
   logic [15:0] stall_mask = 16'hFFFF;
   logic [3:0]  stall_pos  = 4'd0;

   // Parser state mirrored by the predictor
   phase_type   dht_phase;
   logic [15:0] seg_length;
   logic [15:0] seg_consumed;
   logic [3:0]  tbl_class;
   logic [3:0]  tbl_id;
   logic [7:0]  level_counts [NUM_LEVELS];
   logic [4:0]  count_pos;
   logic [4:0]  code_level;
   logic [16:0] code_next;
   logic [7:0]  level_left;
   logic [11:0] symbols_todo;

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // ---------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------

   function automatic void reset_parser();
      dht_phase    = PH_MARK_FF;
      seg_length   = '0;
      seg_consumed = '0;
      tbl_class    = '0;
      tbl_id       = '0;
      for (int i = 0; i < NUM_LEVELS; i++) level_counts[4'(i)] = '0;
      count_pos    = '0;
      code_level   = 5'd1;
      code_next    = '0;
      level_left   = '0;
      symbols_todo = '0;
   endfunction

   // Error beat ends the segment; parser waits for the next marker
   function automatic rsp_type error_beat(input logic [2:0] st);
      rsp_type r;
      dht_phase         = PH_IDLE;
      r                 = '0;
      r.table_class     = tbl_class;
      r.table_id        = tbl_id;
      r.last_of_segment = 1'b1;
      r.status          = st;
      return r;
   endfunction

   // More codes at some length than the code space leaves free
   function automatic bit counts_oversubscribed();
      logic [17:0] avail;
      avail = 18'd1;
      for (int lvl = 1; lvl <= NUM_LEVELS; lvl++) begin
         avail = avail << 1;
         if (lvl > MAX_CODE_LENGTH && level_counts[4'(lvl - 1)] != 0) return 1'b1;
         if (level_counts[4'(lvl - 1)] > avail) return 1'b1;
         avail = avail - level_counts[4'(lvl - 1)];
      end
      return 1'b0;
   endfunction

   // Step past lengths with no codes, doubling the next code each step
   function automatic void skip_empty_lengths();
      while (code_level < NUM_LEVELS && level_counts[4'(code_level - 5'd1)] == 0) begin
         code_next  = code_next << 1;
         code_level = code_level + 5'd1;
      end
      level_left = level_counts[4'(code_level - 5'd1)];
   endfunction

   // One segment byte in; returns 1 when it yields a result beat
   function automatic bit predict_byte(input logic [7:0] b, input logic fb,
                                       output rsp_type r);
      logic        at_end;
      logic [11:0] total;
      logic [16:0] code;
      logic [4:0]  len;
      logic        is_last;
      r = '0;
      if (fb) dht_phase = PH_MARK_FF;

      // Marker and length bytes
      case (dht_phase)
         PH_MARK_FF: begin
            tbl_class = '0;
            tbl_id    = '0;
            if (b != MARKER_FF) begin
               r = error_beat(ST_BAD_MARKER);
               return 1'b1;
            end
            dht_phase = PH_MARK_C4;
            return 1'b0;
         end
         PH_MARK_C4: begin
            if (b != MARKER_DHT) begin
               r = error_beat(ST_BAD_MARKER);
               return 1'b1;
            end
            dht_phase = PH_LEN_HI;
            return 1'b0;
         end
         PH_LEN_HI: begin
            seg_length   = {b, 8'h00};
            seg_consumed = 16'd1;
            dht_phase    = PH_LEN_LO;
            return 1'b0;
         end
         PH_LEN_LO: begin
            seg_length[7:0] = b;
            seg_consumed    = 16'd2;
            if (seg_length < 2) begin
               r = error_beat(ST_OVERRUN);
               return 1'b1;
            end
            dht_phase = (seg_length == 2) ? PH_IDLE : PH_INFO;
            return 1'b0;
         end
         PH_INFO, PH_COUNTS, PH_SYMS: ;
         default: return 1'b0;
      endcase

      seg_consumed = seg_consumed + 16'd1;
      at_end       = (seg_consumed == seg_length);

      // Class/id byte
      if (dht_phase == PH_INFO) begin
         tbl_class = b[7:4];
         tbl_id    = b[3:0];
         if (at_end) begin
            r = error_beat(ST_OVERRUN);
            return 1'b1;
         end
         count_pos = '0;
         dht_phase = PH_COUNTS;
         return 1'b0;
      end

      // Code-length counts; the sixteenth one starts the code walk
      if (dht_phase == PH_COUNTS) begin
         level_counts[count_pos[3:0]] = b;
         if (count_pos < 15) begin
            if (at_end) begin
               r = error_beat(ST_OVERRUN);
               return 1'b1;
            end
            count_pos = count_pos + 5'd1;
            return 1'b0;
         end
         total = '0;
         for (int i = 0; i < NUM_LEVELS; i++) total = total + level_counts[4'(i)];
         if (counts_oversubscribed()) begin
            r = error_beat(ST_OVERSUB);
            return 1'b1;
         end
         if (total == 0) begin
            dht_phase         = at_end ? PH_IDLE : PH_INFO;
            r.table_class     = tbl_class;
            r.table_id        = tbl_id;
            r.last_of_table   = 1'b1;
            r.last_of_segment = at_end;
            r.status          = ST_EMPTY;
            return 1'b1;
         end
         if (at_end) begin
            r = error_beat(ST_OVERRUN);
            return 1'b1;
         end
         symbols_todo = total;
         code_level   = 5'd1;
         code_next    = '0;
         skip_empty_lengths();
         dht_phase = PH_SYMS;
         return 1'b0;
      end

      // Symbol byte: hand out the next canonical code
      code    = code_next;
      len     = code_level;
      is_last = (symbols_todo <= 1);
      if (at_end && !is_last) begin
         r = error_beat(ST_OVERRUN);
         return 1'b1;
      end
      code_next    = code_next + 17'd1;
      level_left   = level_left - 8'd1;
      symbols_todo = symbols_todo - 12'd1;
      if (is_last) begin
         symbols_todo = '0;
         dht_phase    = at_end ? PH_IDLE : PH_INFO;
      end else if (level_left == 0 && code_level < NUM_LEVELS) begin
         code_next  = code_next << 1;
         code_level = code_level + 5'd1;
         skip_empty_lengths();
      end
      r.table_class     = tbl_class;
      r.table_id        = tbl_id;
      r.symbol_value    = b;
      r.code_bits       = code[15:0];
      r.code_length     = len;
      r.last_of_table   = is_last;
      r.last_of_segment = is_last && at_end;
      r.status          = ST_ENTRY;
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------
   // Scoreboard: predict on each byte beat, check each result beat
   // ---------------------------------------------------------------

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : track_beats
      rsp_type want;
      rsp_type got;
      rsp_type owed;
      if (reset) begin
         reset_parser();
      end else begin
         if (req_if.valid && req_if.ready) begin
            if (predict_byte(req_if.data_byte, req_if.first_byte, owed))
               pending_codes.insert(pending_codes.size(), owed);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got.table_class     = rsp_if.table_class;
            got.table_id        = rsp_if.table_id;
            got.symbol_value    = rsp_if.symbol_value;
            got.code_bits       = rsp_if.code_bits;
            got.code_length     = rsp_if.code_length;
            got.last_of_table   = rsp_if.last_of_table;
            got.last_of_segment = rsp_if.last_of_segment;
            got.status          = rsp_if.status;
            if (pending_codes.size() == 0) begin
               $error("result beat with none owed: status %0d symbol 0x%0h",
                      got.status, got.symbol_value);
               mismatch_count++;
            end else begin
               want = pending_codes.pop_front();
               check_field("table_class", 16'(want.table_class), 16'(got.table_class));
               check_field("table_id", 16'(want.table_id), 16'(got.table_id));
               check_field("symbol_value", 16'(want.symbol_value),
                           16'(got.symbol_value));
               check_field("code_bits", want.code_bits, got.code_bits);
               check_field("code_length", 16'(want.code_length), 16'(got.code_length));
               check_field("last_of_table", 16'(want.last_of_table),
                           16'(got.last_of_table));
               check_field("last_of_segment", 16'(want.last_of_segment),
                           16'(got.last_of_segment));
               check_field("status", 16'(want.status), 16'(got.status));
            end
         end
      end
   end

   // Result side stalls on a rotating mask, reloaded each time the bit position wraps
   always @(posedge clock) begin
      if (!stall_on) begin
         rsp_if.ready <= 1'b1;
      end else begin
         rsp_if.ready <= stall_mask[stall_pos];
         stall_pos    <= stall_pos + 4'd1;
         if (stall_pos == 4'd15) stall_mask <= 16'($urandom | $urandom);
      end
   end

   // ---------------------------------------------------------------
   // Byte sender and segment builders
   // ---------------------------------------------------------------

   // One byte beat; bursts of random length with idle gaps between them
   task automatic send_byte(input logic [7:0] d, input logic fb);
      int gap;
      if (gaps_on && burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap        = $urandom_range(1, 6);
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      if (burst_left > 0) burst_left--;
      req_if.valid      <= 1'b1;
      req_if.data_byte  <= d;
      req_if.first_byte <= fb;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   task automatic send_segment(input logic [7:0] q[$], input logic sync);
      for (int i = 0; i < q.size(); i++) send_byte(q[i], sync && (i == 0));
   endtask

   // Stop sending, wait for every owed beat, then let the block settle
   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_codes.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   // Append one byte to a segment under construction
   function automatic void add_byte(ref logic [7:0] q[$], input logic [7:0] b);
      q.insert(q.size(), b);
   endfunction

   // Length field counts itself but not the marker
   function automatic void seal_length(ref logic [7:0] q[$]);
      int len;
      len  = q.size() - 2;
      q[2] = len[15:8];
      q[3] = len[7:0];
   endfunction

   function automatic void start_segment(ref logic [7:0] q[$]);
      q = '{MARKER_FF, MARKER_DHT, 8'h00, 8'h00};
   endfunction

   // Table with counts that fit the code space; optionally complete
   function automatic void add_table(ref logic [7:0] q[$], input int budget,
                                     input bit complete);
      int avail;
      int c;
      int n;
      int lim;
      int fill_at;
      avail   = 1;
      n       = 0;
      fill_at = $urandom_range(1, 8);
      add_byte(q, 8'($urandom_range(0, 255)));
      for (int lvl = 1; lvl <= NUM_LEVELS; lvl++) begin
         avail = avail * 2;
         lim   = (avail < budget - n) ? avail : budget - n;
         if (lim > 255) lim = 255;
         c = 0;
         if (complete && lvl == fill_at && avail <= lim) c = avail;
         else if (lim > 0 && $urandom_range(0, 3) == 0) c = $urandom_range(1, lim);
         avail = avail - c;
         n     = n + c;
         add_byte(q, c[7:0]);
      end
      repeat (n) add_byte(q, 8'($urandom_range(0, 255)));
   endfunction

   function automatic int pick_budget();
      if ($urandom_range(0, 7) == 0) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(13, 200);
      return $urandom_range(1, 12);
   endfunction

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   // After reset the first byte counts as a marker even without first_byte
   task automatic test_marker_after_reset();
      logic [7:0] q[$];
      gaps_on  = 1'b0;
      stall_on = 1'b0;
      q = '{MARKER_FF, MARKER_DHT, 8'h00, 8'h02};
      send_segment(q, 1'b0);
      // idle now: these are dropped
      send_byte(8'h55, 1'b0);
      send_byte(8'hAA, 1'b0);
      drain();
   endtask

   task automatic test_bad_marker();
      logic [7:0] q[$];
      gaps_on  = 1'b1;
      stall_on = 1'b1;
      send_byte(8'h00, 1'b1);
      q = '{MARKER_FF, 8'hC5};
      send_segment(q, 1'b1);
      drain();
   endtask

   task automatic test_length_errors();
      logic [7:0] q[$];
      gaps_on  = 1'b1;
      stall_on = 1'b0;
      q = '{MARKER_FF, MARKER_DHT, 8'h00, 8'h00};
      send_segment(q, 1'b1);
      q = '{MARKER_FF, MARKER_DHT, 8'h00, 8'h01};
      send_segment(q, 1'b1);
      // segment ends on the class/id byte
      q = '{MARKER_FF, MARKER_DHT, 8'h00, 8'h03, 8'h1A};
      send_segment(q, 1'b1);
      // segment ends among the counts
      q = '{MARKER_FF, MARKER_DHT, 8'h00, 8'h06, 8'h00, 8'h00, 8'h00, 8'h00};
      send_segment(q, 1'b1);
      drain();
   endtask

   task automatic test_code_tables();
      logic [7:0] q[$];
      logic [7:0] dc_counts[16];
      gaps_on  = 1'b0;
      stall_on = 1'b1;
      // standard luminance DC table
      dc_counts = '{0, 1, 5, 1, 1, 1, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0};
      start_segment(q);
      add_byte(q, 8'h00);
      for (int i = 0; i < 16; i++) add_byte(q, dc_counts[i]);
      for (int i = 0; i < 12; i++) add_byte(q, i[7:0]);
      seal_length(q);
      send_segment(q, 1'b1);
      // empty table, then a complete code reaching length 16
      start_segment(q);
      add_byte(q, 8'hFF);
      repeat (16) add_byte(q, 8'h00);
      add_byte(q, 8'h10);
      repeat (15) add_byte(q, 8'h01);
      add_byte(q, 8'h02);
      add_byte(q, 8'hFF);
      add_byte(q, 8'h00);
      repeat (15) add_byte(q, 8'($urandom_range(0, 255)));
      seal_length(q);
      send_segment(q, 1'b1);
      // empty table ending the segment
      start_segment(q);
      add_byte(q, 8'h23);
      repeat (16) add_byte(q, 8'h00);
      seal_length(q);
      send_segment(q, 1'b1);
      drain();
   endtask

   task automatic test_oversubscribed();
      logic [7:0] q[$];
      gaps_on  = 1'b1;
      stall_on = 1'b1;
      // over-subscription wins over overrun on the last count
      start_segment(q);
      add_byte(q, 8'h01);
      add_byte(q, 8'h03);
      repeat (15) add_byte(q, 8'h00);
      seal_length(q);
      send_segment(q, 1'b1);
      // one code too many at length 16
      start_segment(q);
      add_byte(q, 8'h12);
      repeat (15) add_byte(q, 8'h01);
      add_byte(q, 8'h03);
      add_byte(q, 8'h00);
      seal_length(q);
      send_segment(q, 1'b1);
      // counts fine but segment ends on the last count
      start_segment(q);
      add_byte(q, 8'h05);
      add_byte(q, 8'h02);
      repeat (15) add_byte(q, 8'h00);
      seal_length(q);
      send_segment(q, 1'b1);
      drain();
   endtask

   task automatic test_symbol_overrun();
      logic [7:0] q[$];
      gaps_on  = 1'b0;
      stall_on = 1'b0;
      start_segment(q);
      add_byte(q, 8'h11);
      add_byte(q, 8'h00);
      add_byte(q, 8'h02);
      repeat (14) add_byte(q, 8'h00);
      add_byte(q, 8'h7E);
      seal_length(q);
      add_byte(q, 8'h81);
      send_segment(q, 1'b1);
      drain();
   endtask

   // first_byte mid-table drops the old segment without a beat
   task automatic test_resync();
      logic [7:0] q[$];
      gaps_on  = 1'b1;
      stall_on = 1'b0;
      start_segment(q);
      add_byte(q, 8'h01);
      add_byte(q, 8'h00);
      add_byte(q, 8'h03);
      repeat (14) add_byte(q, 8'h00);
      add_byte(q, 8'h40);
      add_byte(q, 8'h41);
      add_byte(q, 8'h42);
      seal_length(q);
      q = q[0:21];
      send_segment(q, 1'b1);
      q = '{MARKER_FF, MARKER_DHT, 8'h00, 8'h02};
      send_segment(q, 1'b1);
      drain();
   endtask

   // Mostly well-formed segments with random tables, plus broken ones
   task automatic test_random_segments();
      logic [7:0] q[$];
      int sent;
      int kind;
      int ntab;
      int len;
      int lvl;
      int idx;
      sent = 0;
      while (sent < RANDOM_BYTES) begin
         gaps_on  = ($urandom_range(0, 3) != 0);
         stall_on = ($urandom_range(0, 3) != 0);
         kind     = $urandom_range(0, 99);
         start_segment(q);
         ntab = $urandom_range(1, 3);
         for (int t = 0; t < ntab; t++) add_table(q, pick_budget(), $urandom_range(0, 3) == 0);
         seal_length(q);
         if (kind < 65) begin
            // well-formed
         end else if (kind < 73) begin
            // length too short
            len  = $urandom_range(0, q.size() - 3);
            q[2] = len[15:8];
            q[3] = len[7:0];
         end else if (kind < 79) begin
            // length too long: the next marker cuts it off
            if ($urandom_range(0, 1) == 0) len = $urandom_range(q.size() - 1, q.size() + 8);
            else len = $urandom_range(q.size() - 1, 65535);
            q[2] = len[15:8];
            q[3] = len[7:0];
         end else if (kind < 85) begin
            // one count beyond its length's whole code space
            q    = q[0:20];
            lvl  = $urandom_range(0, 6);
            q[5 + lvl] = 8'($urandom_range((2 << lvl) + 1, 255));
         end else if (kind < 90) begin
            // corrupt marker byte
            idx    = $urandom_range(0, 1);
            q[idx] = q[idx] ^ 8'($urandom_range(1, 255));
            q      = q[0:idx];
         end else if (kind < 95) begin
            // cut short, next segment resyncs
            q = q[0:$urandom_range(0, q.size() - 2)];
         end else begin
            // noise beats
            q = {};
            repeat ($urandom_range(1, 4))
               send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         end
         if (q.size() > 0) send_segment(q, 1'b1);
         sent += q.size();
      end
      drain();
   endtask

   // ---------------------------------------------------------------
   // Run
   // ---------------------------------------------------------------
   initial begin
      reset             <= 1'b1;
      req_if.valid      <= 1'b0;
      req_if.data_byte  <= 8'h00;
      req_if.first_byte <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_marker_after_reset();
      test_bad_marker();
      test_length_errors();
      test_code_tables();
      test_oversubscribed();
      test_symbol_overrun();
      test_resync();
      test_random_segments();

      if (mismatch_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule
